// ===== hw/rtl/skl_pkg.sv =====
package skl_pkg;

    localparam int unsigned FRAC_BITS   = 16;
    localparam int unsigned VAR_W       = 32;
    localparam int unsigned NUM_W       = 64;
    localparam int unsigned TERM_W      = 48;
    localparam int unsigned DIV_STEPS   = NUM_W;
    localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [31:0] FLOOR_RESET = 32'd655360;
    localparam logic [47:0] MAX48       = 48'hFFFF_FFFF_FFFF;
    localparam logic [49:0] TWO_Q16     = 50'd131072;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQR,
        ST_LOAD,
        ST_DIV,
        ST_POST
    } top_state_t;

    typedef enum logic [1:0] {
        A_IDLE,
        A_SUM,
        A_TERM,
        A_ACC
    } acc_state_t;

    typedef struct packed {
        logic [47:0] ratio_a;
        logic [47:0] ratio_b;
        logic [47:0] mean_a;
        logic [47:0] mean_b;
        logic        sat;
        logic        last;
    } skl_term_t;

endpackage

// ===== hw/rtl/skl_div.sv =====
// radix-2 restoring divider, two dividends sharing one divisor
module skl_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] divisor,
    input  logic [63:0] num_a,
    input  logic [63:0] num_b,
    output logic [63:0] quo_a,
    output logic [63:0] quo_b,
    output logic        done
);

    localparam logic [skl_pkg::DIV_CNT_W-1:0] CNT_LAST =
        skl_pkg::DIV_CNT_W'(skl_pkg::DIV_STEPS - 1);

    logic [31:0] dvs_reg;
    logic [63:0] num_a_reg, num_a_next;
    logic [63:0] num_b_reg, num_b_next;
    logic [31:0] rem_a_reg, rem_a_next;
    logic [31:0] rem_b_reg, rem_b_next;
    logic [skl_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [32:0] trial_a, trial_b, diff_a, diff_b;
    logic        ge_a, ge_b;

    always_comb begin
        trial_a    = {rem_a_reg, num_a_reg[63]};
        trial_b    = {rem_b_reg, num_b_reg[63]};
        ge_a       = trial_a >= {1'b0, dvs_reg};
        ge_b       = trial_b >= {1'b0, dvs_reg};
        diff_a     = trial_a - {1'b0, dvs_reg};
        diff_b     = trial_b - {1'b0, dvs_reg};
        rem_a_next = ge_a ? diff_a[31:0] : trial_a[31:0];
        rem_b_next = ge_b ? diff_b[31:0] : trial_b[31:0];
        num_a_next = {num_a_reg[62:0], ge_a};
        num_b_next = {num_b_reg[62:0], ge_b};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_LAST);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvs_reg   <= divisor;
            num_a_reg <= num_a;
            num_b_reg <= num_b;
            rem_a_reg <= '0;
            rem_b_reg <= '0;
        end else if (busy_reg) begin
            num_a_reg <= num_a_next;
            num_b_reg <= num_b_next;
            rem_a_reg <= rem_a_next;
            rem_b_reg <= rem_b_next;
        end
    end

    assign quo_a = num_a_reg;
    assign quo_b = num_b_reg;
    assign done  = done_reg;

endmodule

// ===== hw/rtl/skl_acc.sv =====
// term sum, running total and output register
module skl_acc (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                req_valid,
    input  skl_pkg::skl_term_t  req,
    output logic                ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata,    // distance
    output logic                m_tuser     // overflow
);

    skl_pkg::acc_state_t state_reg, state_next;
    skl_pkg::skl_term_t  term_reg;

    logic [48:0] sum_r_reg, sum_m_reg;
    logic [49:0] dim_reg, dim_next;
    logic [47:0] total_reg, total_next;
    logic        seen_reg, seen_next;
    logic [47:0] out_data_reg, out_data_next;
    logic        out_flag_reg, out_flag_next;
    logic        out_valid_reg, out_valid_next;

    logic [49:0] t_sum;
    logic [50:0] tot;
    logic        tot_sat;
    logic [47:0] tot_clip;
    logic        seen_any;

    always_comb begin
        t_sum    = {1'b0, sum_r_reg} + {1'b0, sum_m_reg};
        dim_next = (t_sum > skl_pkg::TWO_Q16) ? (t_sum - skl_pkg::TWO_Q16) : '0;
        tot      = {3'b0, total_reg} + {1'b0, dim_reg};
        tot_sat  = tot > {3'b0, skl_pkg::MAX48};
        tot_clip = tot_sat ? skl_pkg::MAX48 : tot[47:0];
        seen_any = seen_reg | tot_sat | term_reg.sat;

        state_next     = state_reg;
        total_next     = total_reg;
        seen_next      = seen_reg;
        out_data_next  = out_data_reg;
        out_flag_next  = out_flag_reg;
        out_valid_next = out_valid_reg && !m_tready;

        case (state_reg)
            skl_pkg::A_IDLE: begin
                if (req_valid) begin
                    state_next = skl_pkg::A_SUM;
                end
            end
            skl_pkg::A_SUM: begin
                state_next = skl_pkg::A_TERM;
            end
            skl_pkg::A_TERM: begin
                state_next = skl_pkg::A_ACC;
            end
            skl_pkg::A_ACC: begin
                if (!term_reg.last) begin
                    total_next = tot_clip;
                    seen_next  = seen_any;
                    state_next = skl_pkg::A_IDLE;
                end else if (!out_valid_reg || m_tready) begin
                    out_data_next  = tot_clip;
                    out_flag_next  = seen_any;
                    out_valid_next = 1'b1;
                    total_next     = '0;
                    seen_next      = 1'b0;
                    state_next     = skl_pkg::A_IDLE;
                end
            end
            default: begin
                state_next = skl_pkg::A_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= skl_pkg::A_IDLE;
            total_reg     <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == skl_pkg::A_IDLE && req_valid) begin
            term_reg <= req;
        end
        sum_r_reg    <= {1'b0, term_reg.ratio_a} + {1'b0, term_reg.ratio_b};
        sum_m_reg    <= {1'b0, term_reg.mean_a} + {1'b0, term_reg.mean_b};
        dim_reg      <= dim_next;
        out_data_reg <= out_data_next;
        out_flag_reg <= out_flag_next;
    end

    assign ready    = (state_reg == skl_pkg::A_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_flag_reg;

endmodule

// ===== hw/rtl/symmetric_gaussian_kl_distance.sv =====
// Symmetric KL divergence of two diagonal Gaussians, one dimension per input
// beat, Q16.16 in, Q32.16 saturating total out on the beat with tlast. Each
// dimension holds the input side while it takes the beat and applies the
// variance floor, squares the mean difference, loads the dividers, waits in
// the divide state (64 radix-2 steps of the two shared-divisor dividers, one
// bit per cycle over the 64-bit squared difference, then a wait to see them
// finish), and hands the four quotients to the accumulator once it is ready.
// The accumulator works through its own states but overlaps the next
// dimension. A finished total waits in the output register without blocking
// new beats until the next total is ready behind it. The floor register may
// be written only while the block is idle.
module symmetric_gaussian_kl_distance (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_mean, first_variance, second_mean, second_variance
    input  logic [127:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // distance
    output logic         m_tuser    // overflow
);

    skl_pkg::top_state_t state_reg, state_next;

    logic [31:0] floor_reg;
    logic [31:0] v1_reg, v2_reg;
    logic [31:0] ad_reg;
    logic [63:0] d2_reg;
    logic        last_reg;

    logic [31:0] floor_v, v1_in, v2_in, v1_f, v2_f;
    logic [32:0] diff, diff_abs;
    logic        in_acc;
    logic        div_start;

    logic [63:0] quo1_a, quo1_b, quo2_a, quo2_b;
    logic        done1, done2;

    skl_pkg::skl_term_t term;
    logic               acc_req_valid;
    logic               acc_ready;

    always_comb begin
        floor_v  = (floor_reg == '0) ? 32'd1 : floor_reg;
        v1_in    = s_tdata[63:32];
        v2_in    = s_tdata[127:96];
        v1_f     = (v1_in < floor_v) ? floor_v : v1_in;
        v2_f     = (v2_in < floor_v) ? floor_v : v2_in;
        diff     = {s_tdata[31], s_tdata[31:0]} - {s_tdata[95], s_tdata[95:64]};
        diff_abs = diff[32] ? (33'd0 - diff) : diff;
        in_acc   = s_tvalid && s_tready;
    end

    always_comb begin
        state_next    = state_reg;
        div_start     = 1'b0;
        acc_req_valid = 1'b0;
        case (state_reg)
            skl_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = skl_pkg::ST_SQR;
                end
            end
            skl_pkg::ST_SQR: begin
                state_next = skl_pkg::ST_LOAD;
            end
            skl_pkg::ST_LOAD: begin
                div_start  = 1'b1;
                state_next = skl_pkg::ST_DIV;
            end
            skl_pkg::ST_DIV: begin
                if (done1 && done2) begin
                    state_next = skl_pkg::ST_POST;
                end
            end
            skl_pkg::ST_POST: begin
                if (acc_ready) begin
                    acc_req_valid = 1'b1;
                    state_next    = skl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = skl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= skl_pkg::ST_IDLE;
            floor_reg <= skl_pkg::FLOOR_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                floor_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            v1_reg   <= v1_f;
            v2_reg   <= v2_f;
            ad_reg   <= diff_abs[31:0];
            last_reg <= s_tlast;
        end
        if (state_reg == skl_pkg::ST_SQR) begin
            d2_reg <= {32'b0, ad_reg} * {32'b0, ad_reg};
        end
    end

    assign s_tready = (state_reg == skl_pkg::ST_IDLE);

    // divisor v1: (v2 << 16) / v1 and d^2 / v1
    skl_div u_div1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .divisor (v1_reg),
        .num_a   ({16'b0, v2_reg, 16'b0}),
        .num_b   (d2_reg),
        .quo_a   (quo1_a),
        .quo_b   (quo1_b),
        .done    (done1)
    );

    // divisor v2: (v1 << 16) / v2 and d^2 / v2
    skl_div u_div2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .divisor (v2_reg),
        .num_a   ({16'b0, v1_reg, 16'b0}),
        .num_b   (d2_reg),
        .quo_a   (quo2_a),
        .quo_b   (quo2_b),
        .done    (done2)
    );

    always_comb begin
        term.ratio_a = quo1_a[47:0];
        term.ratio_b = quo2_a[47:0];
        term.mean_a  = (quo1_b[63:48] != '0) ? skl_pkg::MAX48 : quo1_b[47:0];
        term.mean_b  = (quo2_b[63:48] != '0) ? skl_pkg::MAX48 : quo2_b[47:0];
        term.sat     = (quo1_b[63:48] != '0) || (quo2_b[63:48] != '0);
        term.last    = last_reg;
    end

    skl_acc u_acc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (acc_req_valid),
        .req       (term),
        .ready     (acc_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        done1 == done2)
        else $error("dividers out of step");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        done1 |-> state_reg == skl_pkg::ST_DIV)
        else $error("divider finished outside divide state");

    a_acc_handoff: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_req_valid |=> !acc_ready)
        else $error("accumulator did not take hand-off");

endmodule
